// ----- design/prsu_pkg.sv -----
package prsu_pkg;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_PIVOT_X     = 3'd0,
        CFG_PIVOT_Y     = 3'd1,
        CFG_PIVOT_Z     = 3'd2,
        CFG_LOOP_ENABLE = 3'd3,
        CFG_ACTIVE      = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQ,
        ST_SQRT,
        ST_MV,
        ST_DIV,
        ST_MUL,
        ST_APPLY,
        ST_AGE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_SQRT,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [63:0] num;
        logic [63:0] den;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } unit_rsp_t;

    localparam logic [34:0] MOVE_MAX = 35'h3_FFFF_FFFF;

endpackage

// ----- design/prsu_if.sv -----
interface prsu_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  cmd;
    logic [5:0]  index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] speed;
    logic [31:0] lifetime;
    logic [31:0] time_step;
    modport source (output valid, cmd, index, pos_x, pos_y, pos_z, speed, lifetime,
                    time_step, input ready);
    modport sink (input valid, cmd, index, pos_x, pos_y, pos_z, speed, lifetime,
                  time_step, output ready);
endinterface

interface prsu_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  out_index;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_age;
    logic        last;
    modport source (output valid, out_index, out_x, out_y, out_z, out_age, last,
                    input ready);
    modport sink (input valid, out_index, out_x, out_y, out_z, out_age, last,
                  output ready);
endinterface

// ----- design/prsu_unit.sv -----
module prsu_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  prsu_pkg::unit_req_t req,
    output prsu_pkg::unit_rsp_t rsp
);
    import prsu_pkg::*;

    logic        busy_reg, busy_next;
    op_t         op_reg, op_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] num_reg, num_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        done_next = 1'b0;
        rem_sh    = '0;
        trial     = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            rem_next  = '0;
            quo_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            cnt_next  = (req.op == OP_SQRT) ? 7'd32 : 7'd64;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_SQRT:
                begin
                    rem_sh = {rem_reg[61:0], num_reg[63:62]};
                    trial  = {1'b0, rem_sh} - {1'b0, quo_reg[61:0], 2'b01};
                    num_next = {num_reg[61:0], 2'b00};
                    if (!trial[64])
                    begin
                        rem_next = trial[63:0];
                        quo_next = {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    rem_sh = {rem_reg[62:0], num_reg[63]};
                    trial  = {rem_reg[63], rem_sh} - {1'b0, den_reg};
                    num_next = {num_reg[62:0], 1'b0};
                    if (!trial[64])
                    begin
                        rem_next = trial[63:0];
                        quo_next = {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[62:0], 1'b0};
                    end
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_SQRT;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        num_reg <= num_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = quo_reg;
endmodule

// ----- design/particle_radial_spread_update.sv -----
// Load item: accepted, no result.
// Tick item: one result per walked entry; an entry on the pivot skips the divisions. One shared
// shift-subtract unit runs the 32-step square root and the three 64-step divisions.
// A tick walks up to 64 entries and can wait on the output handshake.
// One item at a time; in.ready is low while a tick walks the table.
// rst_n clears control and configuration; the particle table is not cleared.
module particle_radial_spread_update #(
    parameter int NUM_PARTICLES = 64,
    parameter int FRAC_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    prsu_in_if.sink     in,
    prsu_out_if.source  out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import prsu_pkg::*;

    localparam int IW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam logic [6:0] NP7 = 7'(NUM_PARTICLES);

    logic [31:0] mem_sx [NUM_PARTICLES];
    logic [31:0] mem_sy [NUM_PARTICLES];
    logic [31:0] mem_sz [NUM_PARTICLES];
    logic [31:0] mem_cx [NUM_PARTICLES];
    logic [31:0] mem_cy [NUM_PARTICLES];
    logic [31:0] mem_cz [NUM_PARTICLES];
    logic [31:0] mem_sp [NUM_PARTICLES];
    logic [31:0] mem_ag [NUM_PARTICLES];
    logic [31:0] mem_lf [NUM_PARTICLES];

    logic [31:0] pivot_x_reg, pivot_y_reg, pivot_z_reg;
    logic        loop_reg;
    logic [6:0]  active_reg;

    state_t      state_reg, state_next;
    logic [6:0]  idx_reg, idx_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] step_reg;
    logic [1:0]  axis_reg, axis_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] rcx, rcy, rcz, rsx, rsy, rsz, rsp, rag, rlf;
    logic [32:0] d_reg [3];
    logic [32:0] a_reg [3];
    logic [63:0] sq_reg;
    logic [1:0]  sq_cnt_reg;
    logic [63:0] len_reg;
    logic [63:0] mv_reg;
    logic [63:0] u_reg;
    logic [63:0] prod_reg;
    logic [66:0] prod_w;
    logic [31:0] nx_reg [3];
    logic [5:0]  o_idx_reg;
    logic [31:0] o_x_reg, o_y_reg, o_z_reg, o_age_reg;
    logic        o_last_reg;

    unit_req_t   req;
    unit_rsp_t   rsp_u;

    prsu_unit u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp_u));

    logic [IW-1:0] ridx;
    assign ridx = idx_reg[IW-1:0];

    logic in_fire;
    assign in_fire = in.valid && in.ready;
    assign in.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            pivot_z_reg <= '0;
            loop_reg    <= 1'b0;
            active_reg  <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIVOT_X:     pivot_x_reg <= cfg_data;
                CFG_PIVOT_Y:     pivot_y_reg <= cfg_data;
                CFG_PIVOT_Z:     pivot_z_reg <= cfg_data;
                CFG_LOOP_ENABLE: loop_reg    <= cfg_data[0];
                CFG_ACTIVE:      active_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [32:0] dsel;
    logic [31:0] csel;
    logic        ld_we;
    assign ld_we = in_fire && (in.cmd == CMD_LOAD) && (7'(in.index) < NP7);

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    begin dsel = d_reg[0]; csel = rcx; end
            2'd1:    begin dsel = d_reg[1]; csel = rcy; end
            default: begin dsel = d_reg[2]; csel = rcz; end
        endcase
    end

    logic [35:0] p_new;
    logic [31:0] p_sat;
    always_comb
    begin
        if (dsel[32])
            p_new = {{4{csel[31]}}, csel} - {1'b0, prod_reg[34:0]};
        else
            p_new = {{4{csel[31]}}, csel} + {1'b0, prod_reg[34:0]};
        if (!p_new[35] && (p_new[34:31] != 4'b0000))
            p_sat = 32'h7FFF_FFFF;
        else if (p_new[35] && (p_new[34:31] != 4'b1111))
            p_sat = 32'h8000_0000;
        else
            p_sat = p_new[31:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out.ready;
        req.start      = 1'b0;
        req.op         = OP_SQRT;
        req.num        = sq_reg;
        req.den        = len_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in.cmd == CMD_TICK)
                begin
                    cnt_next = (active_reg > NP7) ? NP7 : active_reg;
                    idx_next = '0;
                    if (cnt_next != 7'd0)
                        state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_SQ;
            ST_SQ:
            begin
                if (sq_cnt_reg == 2'd3)
                begin
                    req.start  = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (rsp_u.done)
                    state_next = ST_MV;
            end
            ST_MV:
            begin
                axis_next = 2'd0;
                state_next = (len_reg == '0) ? ST_AGE : ST_DIV;
                if (len_reg != '0)
                begin
                    req.start = 1'b1;
                    req.op    = OP_DIV;
                    req.num   = {a_reg[0][33-3:0], 30'd0} ;
                end
            end
            ST_DIV:
            begin
                if (rsp_u.done)
                    state_next = ST_MUL;
            end
            ST_MUL:   state_next = ST_APPLY;
            ST_APPLY:
            begin
                if (axis_reg == 2'd2)
                    state_next = ST_AGE;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    req.num    = (axis_reg == 2'd0) ? {a_reg[1][30:0], 30'd0, 3'd0} >> 3
                                                    : {a_reg[2][30:0], 30'd0, 3'd0} >> 3;
                    state_next = ST_DIV;
                end
            end
            ST_AGE:
            begin
                if (!out_valid_reg || out.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            default:
            begin
                if (idx_reg + 7'd1 == cnt_reg)
                    state_next = ST_IDLE;
                else
                begin
                    idx_next   = idx_reg + 7'd1;
                    state_next = ST_READ;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            sq_cnt_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            sq_cnt_reg    <= (state_reg == ST_SQ) ? sq_cnt_reg + 2'd1 : 2'd0;
        end
    end

    logic [32:0] dx, dy, dz, ax, ay, az;
    logic        big;
    logic [64:0] mvw;
    logic [32:0] age_sum;
    logic        expire;
    logic [32:0] asq;

    always_comb
    begin
        dx = {rcx[31], rcx} - {pivot_x_reg[31], pivot_x_reg};
        dy = {rcy[31], rcy} - {pivot_y_reg[31], pivot_y_reg};
        dz = {rcz[31], rcz} - {pivot_z_reg[31], pivot_z_reg};
        ax = dx[32] ? -dx : dx;
        ay = dy[32] ? -dy : dy;
        az = dz[32] ? -dz : dz;
        big = ax[32] | ax[31] | ay[32] | ay[31] | az[32] | az[31];
        mvw = ({32'd0, rsp} * {32'd0, step_reg}) >> FRAC_BITS;
        age_sum = {1'b0, rag} + {1'b0, step_reg};
        unique case (sq_cnt_reg)
            2'd0:    asq = a_reg[0];
            2'd1:    asq = a_reg[1];
            default: asq = a_reg[2];
        endcase
    end

    assign prod_w = {36'd0, u_reg[30:0]} * {32'd0, mv_reg[34:0]};

    logic [31:0] age_sat;
    assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign expire  = loop_reg && (age_sat >= rlf);

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            mem_sx[in.index[IW-1:0]] <= in.pos_x;
            mem_sy[in.index[IW-1:0]] <= in.pos_y;
            mem_sz[in.index[IW-1:0]] <= in.pos_z;
            mem_cx[in.index[IW-1:0]] <= in.pos_x;
            mem_cy[in.index[IW-1:0]] <= in.pos_y;
            mem_cz[in.index[IW-1:0]] <= in.pos_z;
            mem_sp[in.index[IW-1:0]] <= in.speed;
            mem_lf[in.index[IW-1:0]] <= in.lifetime;
            mem_ag[in.index[IW-1:0]] <= '0;
        end
        else if (state_reg == ST_AGE && state_next == ST_EMIT)
        begin
            mem_ag[ridx] <= expire ? 32'd0 : age_sat;
            mem_cx[ridx] <= expire ? rsx : nx_reg[0];
            mem_cy[ridx] <= expire ? rsy : nx_reg[1];
            mem_cz[ridx] <= expire ? rsz : nx_reg[2];
        end
        if (state_reg == ST_READ)
        begin
            rcx <= mem_cx[ridx];
            rcy <= mem_cy[ridx];
            rcz <= mem_cz[ridx];
            rsx <= mem_sx[ridx];
            rsy <= mem_sy[ridx];
            rsz <= mem_sz[ridx];
            rsp <= mem_sp[ridx];
            rag <= mem_ag[ridx];
            rlf <= mem_lf[ridx];
        end
        if (in_fire)
            step_reg <= in.time_step;
        if (state_reg == ST_DIFF)
        begin
            d_reg[0] <= dx;
            d_reg[1] <= dy;
            d_reg[2] <= dz;
            a_reg[0] <= big ? ax >> 1 : ax;
            a_reg[1] <= big ? ay >> 1 : ay;
            a_reg[2] <= big ? az >> 1 : az;
            nx_reg[0] <= rcx;
            nx_reg[1] <= rcy;
            nx_reg[2] <= rcz;
            sq_reg   <= '0;
        end
        if (state_reg == ST_SQ && sq_cnt_reg != 2'd3)
            sq_reg <= sq_reg + ({32'd0, asq[31:0]} * {32'd0, asq[31:0]});
        if (state_reg == ST_SQRT && rsp_u.done)
            len_reg <= rsp_u.res;
        if (state_reg == ST_SQRT)
            mv_reg <= (mvw[64:34] != '0) ? {29'd0, MOVE_MAX} : mvw[63:0];
        if (state_reg == ST_DIV && rsp_u.done)
            u_reg <= rsp_u.res;
        if (state_reg == ST_MUL)
            prod_reg <= {27'd0, prod_w[66:30]};
        if (state_reg == ST_APPLY)
        begin
            unique case (axis_reg)
                2'd0:    nx_reg[0] <= p_sat;
                2'd1:    nx_reg[1] <= p_sat;
                default: nx_reg[2] <= p_sat;
            endcase
        end
        if (state_reg == ST_AGE && state_next == ST_EMIT)
        begin
            o_idx_reg  <= 6'(idx_reg);
            o_x_reg    <= expire ? rsx : nx_reg[0];
            o_y_reg    <= expire ? rsy : nx_reg[1];
            o_z_reg    <= expire ? rsz : nx_reg[2];
            o_age_reg  <= expire ? 32'd0 : age_sat;
            o_last_reg <= (idx_reg + 7'd1 == cnt_reg);
        end
    end

    assign out.valid     = out_valid_reg;
    assign out.out_index = o_idx_reg;
    assign out.out_x     = o_x_reg;
    assign out.out_y     = o_y_reg;
    assign out.out_z     = o_z_reg;
    assign out.out_age   = o_age_reg;
    assign out.last      = o_last_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in.ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> out_valid_reg)
        else $error("emit without valid");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg < cnt_reg))
        else $error("index beyond count");
endmodule

// ----- bench/particle_radial_spread_update_test.sv -----
`timescale 1ns / 1ps

module particle_radial_spread_update_test;
    import prsu_pkg::*;

    localparam int  ENTRIES     = 64;
    localparam int  FRAC        = 16;
    localparam int  CYCLE_LIMIT = 12_000_000;
    localparam int  SETTLE      = 16;

    typedef struct {
        cmd_t        cmd;
        logic [5:0]  index;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] speed;
        logic [31:0] lifetime;
        logic [31:0] time_step;
    } particle_cmd_t;

    typedef struct {
        logic [5:0]  index;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] age;
        logic        last;
    } particle_pos_t;

    typedef struct {
        int            loop_cfg;
        particle_cmd_t item;
        bit            typed;
        particle_pos_t want;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    prsu_in_if  in_ch ();
    prsu_out_if out_ch ();

    particle_radial_spread_update DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [31:0] start_x [ENTRIES];
    logic [31:0] start_y [ENTRIES];
    logic [31:0] start_z [ENTRIES];
    logic [31:0] pos_x   [ENTRIES];
    logic [31:0] pos_y   [ENTRIES];
    logic [31:0] pos_z   [ENTRIES];
    logic [31:0] speed   [ENTRIES];
    logic [31:0] age     [ENTRIES];
    logic [31:0] life    [ENTRIES];
    bit          loaded  [ENTRIES];
    logic [31:0] pivot_x;
    logic [31:0] pivot_y;
    logic [31:0] pivot_z;
    logic        loop_on;
    logic [6:0]  walk_count;

    particle_pos_t positions_due [$];
    int  errors;
    int  cycles;
    bit  quiet;
    int  out_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] push_axis(logic [31:0] cur, bit neg, logic [63:0] mag,
                                              logic [63:0] len, logic [63:0] mv);
        logic [63:0] unit;
        logic [63:0] delta;
        longint      p;
        unit  = (mag << 30) / len;
        delta = (unit * mv) >> 30;
        p = longint'($signed(cur));
        if (neg)
            p = p - longint'(delta);
        else
            p = p + longint'(delta);
        if (p > 64'sh7FFF_FFFF)
            p = 64'sh7FFF_FFFF;
        if (p < -64'sh8000_0000)
            p = -64'sh8000_0000;
        return p[31:0];
    endfunction

    task automatic advance_particles(input particle_cmd_t it, output particle_pos_t res[$]);
        int          n;
        longint      dx;
        longint      dy;
        longint      dz;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] az;
        logic [63:0] len;
        logic [63:0] mv;
        logic [63:0] grown;
        particle_pos_t r;
        res.delete();
        if (it.cmd == CMD_LOAD)
        begin
            start_x[it.index] = it.pos_x;
            start_y[it.index] = it.pos_y;
            start_z[it.index] = it.pos_z;
            pos_x[it.index]   = it.pos_x;
            pos_y[it.index]   = it.pos_y;
            pos_z[it.index]   = it.pos_z;
            speed[it.index]   = it.speed;
            life[it.index]    = it.lifetime;
            age[it.index]     = 0;
            loaded[it.index]  = 1;
            return;
        end
        n = (walk_count > ENTRIES) ? ENTRIES : walk_count;
        for (int i = 0; i < n; i++)
        begin
            dx = longint'($signed(pos_x[i])) - longint'($signed(pivot_x));
            dy = longint'($signed(pos_y[i])) - longint'($signed(pivot_y));
            dz = longint'($signed(pos_z[i])) - longint'($signed(pivot_z));
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            az = (dz < 0) ? -dz : dz;
            if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000 || az >= 64'h8000_0000)
            begin
                ax = ax >> 1;
                ay = ay >> 1;
                az = az >> 1;
            end
            len = root64(ax * ax + ay * ay + az * az);
            mv = ({32'd0, speed[i]} * {32'd0, it.time_step}) >> FRAC;
            if (mv > {29'd0, MOVE_MAX})
                mv = {29'd0, MOVE_MAX};
            if (len != 0)
            begin
                pos_x[i] = push_axis(pos_x[i], dx < 0, ax, len, mv);
                pos_y[i] = push_axis(pos_y[i], dy < 0, ay, len, mv);
                pos_z[i] = push_axis(pos_z[i], dz < 0, az, len, mv);
            end
            grown = {32'd0, age[i]} + {32'd0, it.time_step};
            age[i] = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            if (loop_on && age[i] >= life[i])
            begin
                age[i]   = 0;
                pos_x[i] = start_x[i];
                pos_y[i] = start_y[i];
                pos_z[i] = start_z[i];
            end
            r.index = i[5:0];
            r.x     = pos_x[i];
            r.y     = pos_y[i];
            r.z     = pos_z[i];
            r.age   = age[i];
            r.last  = (i + 1 == n);
            res.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_hold = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (positions_due.size() == 0)
                begin
                    $error("result with nothing expected: index %0d", out_ch.out_index);
                    errors++;
                end
                else
                begin
                    particle_pos_t w;
                    w = positions_due.pop_front();
                    if (out_ch.out_index !== w.index)
                    begin
                        $error("out_index expected %0d got %0d", w.index, out_ch.out_index);
                        errors++;
                    end
                    if (out_ch.out_x !== w.x)
                    begin
                        $error("out_x expected %h got %h", w.x, out_ch.out_x);
                        errors++;
                    end
                    if (out_ch.out_y !== w.y)
                    begin
                        $error("out_y expected %h got %h", w.y, out_ch.out_y);
                        errors++;
                    end
                    if (out_ch.out_z !== w.z)
                    begin
                        $error("out_z expected %h got %h", w.z, out_ch.out_z);
                        errors++;
                    end
                    if (out_ch.out_age !== w.age)
                    begin
                        $error("out_age expected %h got %h", w.age, out_ch.out_age);
                        errors++;
                    end
                    if (out_ch.last !== w.last)
                    begin
                        $error("last expected %0d got %0d", w.last, out_ch.last);
                        errors++;
                    end
                end
                out_hold = quiet ? 0 : $urandom_range(0, 19);
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send(input particle_cmd_t it, input bit typed, input particle_pos_t want);
        particle_pos_t got[$];
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= it.cmd;
        in_ch.index     <= it.index;
        in_ch.pos_x     <= it.pos_x;
        in_ch.pos_y     <= it.pos_y;
        in_ch.pos_z     <= it.pos_z;
        in_ch.speed     <= it.speed;
        in_ch.lifetime  <= it.lifetime;
        in_ch.time_step <= it.time_step;
        do
            @(posedge clk);
        while (!in_ch.ready);
        advance_particles(it, got);
        if (typed)
        begin
            got.delete();
            got.push_back(want);
        end
        foreach (got[k])
            positions_due.push_back(got[k]);
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (positions_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PIVOT_X:     pivot_x = value;
            CFG_PIVOT_Y:     pivot_y = value;
            CFG_PIVOT_Z:     pivot_z = value;
            CFG_LOOP_ENABLE: loop_on = value[0];
            CFG_ACTIVE:      walk_count = value[6:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_cmd_t random_load(int idx);
        particle_cmd_t it;
        it.cmd       = CMD_LOAD;
        it.index     = idx[5:0];
        it.pos_x     = pick_word();
        it.pos_y     = pick_word();
        it.pos_z     = pick_word();
        it.speed     = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h4_0000);
        it.lifetime  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h8_0000);
        it.time_step = $urandom;
        return it;
    endfunction

    function automatic particle_cmd_t random_tick();
        particle_cmd_t it;
        it = random_load(0);
        it.cmd       = CMD_TICK;
        it.index     = $urandom;
        it.time_step = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h3_0000);
        return it;
    endfunction

    function automatic directed_row_t row(int lc, cmd_t c, int idx, logic [31:0] x,
                                          logic [31:0] y, logic [31:0] z, logic [31:0] sp,
                                          logic [31:0] lt, logic [31:0] st, bit typed,
                                          logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                                          logic [31:0] wage);
        directed_row_t r;
        r.loop_cfg       = lc;
        r.item.cmd       = c;
        r.item.index     = idx[5:0];
        r.item.pos_x     = x;
        r.item.pos_y     = y;
        r.item.pos_z     = z;
        r.item.speed     = sp;
        r.item.lifetime  = lt;
        r.item.time_step = st;
        r.typed          = typed;
        r.want.index     = 6'd0;
        r.want.x         = wx;
        r.want.y         = wy;
        r.want.z         = wz;
        r.want.age       = wage;
        r.want.last      = 1'b1;
        return r;
    endfunction

    directed_row_t table_rows[$];

    initial
    begin
        int eff;
        int cnt;
        int n_items;
        particle_cmd_t it;
        particle_pos_t none;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_LOAD;
        in_ch.index     = '0;
        in_ch.pos_x     = '0;
        in_ch.pos_y     = '0;
        in_ch.pos_z     = '0;
        in_ch.speed     = '0;
        in_ch.lifetime  = '0;
        in_ch.time_step = '0;
        out_ch.ready    = 1'b0;
        errors          = 0;
        cycles          = 0;
        quiet           = 0;
        pivot_x         = 0;
        pivot_y         = 0;
        pivot_z         = 0;
        loop_on         = 0;
        walk_count      = 7'd64;
        none            = '{default: '0};
        for (int i = 0; i < ENTRIES; i++)
        begin
            start_x[i] = 0; start_y[i] = 0; start_z[i] = 0;
            pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
            speed[i] = 0; age[i] = 0; life[i] = 0; loaded[i] = 0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_ACTIVE, 32'd1);

        // zero direction, then age saturation
        table_rows.push_back(row(-1, CMD_LOAD, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                                 0, 0, 0, 0, 0));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
                                 1, 0, 0, 0, 32'hFFFF_FFFF));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 32'd1,
                                 1, 0, 0, 0, 32'hFFFF_FFFF));
        table_rows.push_back(row(-1, CMD_LOAD, 63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 0, 0, 0, 0, 0, 0, 0, 0));
        // one unit along x
        table_rows.push_back(row(-1, CMD_LOAD, 0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h3_0000, 0,
                                 0, 0, 0, 0, 0));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 32'h1_0000,
                                 1, 32'h2_0000, 0, 0, 32'h1_0000));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 0,
                                 1, 32'h2_0000, 0, 0, 32'h1_0000));
        // position saturation at both ends
        table_rows.push_back(row(-1, CMD_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                                 32'hFFFF_FFFF, 32'd1, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
                                 0, 0, 0, 0, 0));
        table_rows.push_back(row(-1, CMD_LOAD, 0, 32'hFFFF_0000, 32'h0003_0000, 32'hFFFC_0000,
                                 32'h0002_8000, 32'h0004_0000, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 32'h0000_C000,
                                 0, 0, 0, 0, 0));
        // loop mode: expiry restarts at the start position
        table_rows.push_back(row(1, CMD_LOAD, 0, 32'h5_0000, 32'h6_0000, 32'hFFF9_0000,
                                 32'h1_0000, 32'h1_0000, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 32'h1_0000,
                                 1, 32'h5_0000, 32'h6_0000, 32'hFFF9_0000, 0));
        table_rows.push_back(row(-1, CMD_LOAD, 0, 32'h5_0000, 32'h6_0000, 32'hFFF9_0000,
                                 32'h1_0000, 32'h0, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 0,
                                 1, 32'h5_0000, 32'h6_0000, 32'hFFF9_0000, 0));
        table_rows.push_back(row(-1, CMD_TICK, 0, 0, 0, 0, 0, 0, 32'h8000,
                                 0, 0, 0, 0, 0));

        foreach (table_rows[r])
        begin
            if (table_rows[r].loop_cfg >= 0)
            begin
                drain();
                write_reg(CFG_LOOP_ENABLE, table_rows[r].loop_cfg);
            end
            send(table_rows[r].item, table_rows[r].typed, table_rows[r].want);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            quiet = (ph % 4 == 1);
            write_reg(CFG_PIVOT_X, pick_word());
            write_reg(CFG_PIVOT_Y, pick_word());
            write_reg(CFG_PIVOT_Z, pick_word());
            write_reg(CFG_LOOP_ENABLE, $urandom_range(0, 1));
            if (ph == 8)
                cnt = 127;
            else if (ph == 9)
                cnt = 64;
            else if (ph == 3)
                cnt = 0;
            else
                cnt = $urandom_range(1, 8);
            write_reg(CFG_ACTIVE, cnt);
            eff = (cnt > ENTRIES) ? ENTRIES : cnt;
            for (int i = 0; i < eff; i++)
                if (!loaded[i])
                    send(random_load(i), 0, none);
            n_items = (ph >= 8) ? 3 : 10;
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 9) < 6)
                    it = random_tick();
                else if ($urandom_range(0, 1) == 0 || eff == 0)
                    it = random_load($urandom_range(0, 63));
                else
                    it = random_load($urandom_range(0, eff - 1));
                send(it, 0, none);
            end
        end

        quiet = 0;
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
design/prsu_pkg.sv
design/prsu_if.sv
design/prsu_unit.sv
design/particle_radial_spread_update.sv
bench/particle_radial_spread_update_test.sv
